@@ rtl/mmo_pkg.sv @@
package mmo_pkg;

	localparam int LenBits = 61;

	// byte count as kept by the front end
	typedef logic [LenBits-1:0] len_t;

	// one block handed from the front end to the compression unit
	typedef struct packed {
		logic [127:0] blk;   // byte 0 in bits 127:120
		logic         last;  // emit digest and clear chaining value after this block
	} blk_req_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef logic [7:0] sbox_arr_t [256];

	localparam sbox_arr_t SBOX = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a 128-bit word, byte 0 on top
	function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
		return w[127-8*i -: 8];
	endfunction

endpackage

@@ rtl/mmo_aes128_stream_hash_top.sv @@
// channel | direction | fields
// in      | input     | op, data_byte (valid/stall)
// out     | output    | digest_hi, digest_lo (valid/stall)
// Bytes are taken one per cycle while the input is not stalled; a full block goes to a two-entry queue.
// The AES unit runs one round per cycle and takes no new block while busy
// or while a digest waits. A finish costs one or two blocks.
// A finish with 8 or more bytes held stalls the input while the length block is owed.
// arst_n clears chaining value, counts and queue; out stall backs up to in.
module mmo_aes128_stream_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_hi,
	output logic [63:0] digest_lo
);

	mmo_pkg::blk_req_t f_req, q_req;
	logic f_valid, f_stall, q_valid, q_stall;

	mmo_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .op, .data_byte,
		.req_valid(f_valid), .req_stall(f_stall), .req(f_req)
	);

	mmo_fifo u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_stall(f_stall), .in_req(f_req),
		.out_valid(q_valid), .out_stall(q_stall), .out_req(q_req)
	);

	mmo_core u_core (
		.clk, .arst_n, .req_valid(q_valid), .req_stall(q_stall), .req(q_req),
		.valid(out_valid), .stall(out_stall), .digest_hi, .digest_lo
	);

endmodule

@@ rtl/mmo_front.sv @@
// Byte collector and padder: builds 16-byte blocks, hands them to the queue.
module mmo_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic                 op,
	input  logic [7:0]           data_byte,
	output logic                 req_valid,
	input  logic                 req_stall,
	output mmo_pkg::blk_req_t    req
);

	logic [127:0]        buf_q;
	logic [3:0]          fill_q;
	mmo_pkg::len_t       len_q;
	logic                pend_q;   // length block still owed after a split finish
	logic [127:0]        nbuf;
	logic [127:0]        padded;
	logic                accept;
	logic [63:0]         bits;

	// bit length from the count after this message
	assign bits = {{(64-mmo_pkg::LenBits-3){1'b0}}, len_q, 3'b000};

	// insert the current byte, then zero fill behind the marker
	always_comb begin
		nbuf = buf_q;
		nbuf[127-8*fill_q -: 8] = (op == mmo_pkg::OP_FINISH) ? 8'h80 : data_byte;
		padded = nbuf;
		for (int i = 0; i < 16; i++) begin
			if (i > int'(fill_q)) padded[127-8*i -: 8] = 8'h00;
		end
	end

	// hold new items while a length block is still owed or the queue stalls
	assign stall  = pend_q || req_stall;
	assign accept = valid && !stall;

	always_comb begin
		req_valid = 1'b0;
		req.blk   = padded;
		req.last  = 1'b0;
		if (pend_q) begin
			req_valid = 1'b1;
			req.blk   = {64'h0, bits};
			req.last  = 1'b1;
		end else if (valid) begin
			if (op == mmo_pkg::OP_ABSORB) begin
				req_valid = (fill_q == 4'd15);
				req.blk   = nbuf;
			end else begin
				req_valid = 1'b1;
				if (fill_q < 4'd8) begin
					req.blk  = {padded[127:64], bits};
					req.last = 1'b1;
				end
			end
		end
	end

	// advance the fill count and the byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			if (!req_stall) begin
				pend_q <= 1'b0;
				len_q  <= '0;
			end
		end else if (accept) begin
			if (op == mmo_pkg::OP_ABSORB) begin
				fill_q <= fill_q + 4'd1;
				len_q  <= len_q + mmo_pkg::len_t'(1);
			end else begin
				fill_q <= '0;
				if (fill_q < 4'd8) len_q <= '0;
				else pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) buf_q <= nbuf;
	end

endmodule

@@ rtl/mmo_fifo.sv @@
// Two-entry queue of blocks between collector and compression unit.
module mmo_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mmo_pkg::blk_req_t in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output mmo_pkg::blk_req_t out_req
);

	mmo_pkg::blk_req_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req   = mem_q[rp_q];
	assign wr = in_valid && !in_stall;
	assign rd = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_req;
	end

endmodule

@@ rtl/mmo_core.sv @@
// Iterative AES-128 round unit, one round per cycle, with chaining value.
module mmo_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  mmo_pkg::blk_req_t req,
	output logic              valid,
	input  logic              stall,
	output logic [63:0]       digest_hi,
	output logic [63:0]       digest_lo
);

	logic [127:0] h_q, st_q, rk_q, blk_q;
	logic [3:0]   rnd_q;
	logic [7:0]   rcon_q;
	logic         busy_q, last_q, ovld_q;
	logic [127:0] sb, mc, nrk, nst;
	logic         start, done;

	// accept a block when idle and no digest is waiting
	assign req_stall = busy_q || ovld_q;
	assign start     = req_valid && !req_stall;
	assign done      = busy_q && (rnd_q == 4'd10);

	// one round: sub bytes with shift rows, mix columns (skipped in round ten), key schedule
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[127-8*(r+4*c) -: 8] =
					mmo_pkg::SBOX[mmo_pkg::byte_of(st_q, r + 4*((c + r) & 3))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, s;
			a0 = sb[127-32*c -: 8];
			a1 = sb[119-32*c -: 8];
			a2 = sb[111-32*c -: 8];
			a3 = sb[103-32*c -: 8];
			s  = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ s ^ mmo_pkg::xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ s ^ mmo_pkg::xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ s ^ mmo_pkg::xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ s ^ mmo_pkg::xtime(a3 ^ a0);
		end
		nrk[127:96] = rk_q[127:96] ^ {mmo_pkg::SBOX[rk_q[23:16]] ^ rcon_q,
			mmo_pkg::SBOX[rk_q[15:8]], mmo_pkg::SBOX[rk_q[7:0]],
			mmo_pkg::SBOX[rk_q[31:24]]};
		nrk[95:64] = rk_q[95:64] ^ nrk[127:96];
		nrk[63:32] = rk_q[63:32] ^ nrk[95:64];
		nrk[31:0]  = rk_q[31:0]  ^ nrk[63:32];
		nst = ((rnd_q == 4'd10) ? sb : mc) ^ nrk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovld_q <= 1'b0;
			h_q    <= '0;
			rnd_q  <= '0;
		end else begin
			if (ovld_q && !stall) ovld_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
			end else if (done) begin
				busy_q <= 1'b0;
				// feed forward, drop chaining value after a digest
				h_q    <= last_q ? '0 : (nst ^ blk_q);
				ovld_q <= last_q;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q   <= req.blk ^ h_q;
			rk_q   <= h_q;
			blk_q  <= req.blk;
			last_q <= req.last;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			st_q   <= nst;
			rk_q   <= nrk;
			rcon_q <= mmo_pkg::xtime(rcon_q);
		end
		if (done && last_q) begin
			digest_hi <= nst[127:64] ^ blk_q[127:64];
			digest_lo <= nst[63:0] ^ blk_q[63:0];
		end
	end

	assign valid = ovld_q;

`ifndef SYNTHESIS
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10))
		else $error("round count out of range");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("block started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy_q)
		else $error("unit still busy after round ten");
`endif

endmodule

@@ tb/mmo_aes128_stream_hash_top_tb.sv @@
module mmo_aes128_stream_hash_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_hi;
	logic [63:0] digest_lo;

	mmo_aes128_stream_hash_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_hi(digest_hi), .digest_lo(digest_lo)
	);

	// hash state as the predictor sees it
	logic [127:0]   chain_h;
	logic [7:0]     blk_buf [16];
	int             fill_cnt;
	mmo_pkg::len_t  msg_len;

	logic [127:0] digest_q [$];
	int           mismatches;
	int           cycle_cnt;
	bit           hold_off;
	int           hold_cycles;
	int           rx_wait;

	logic [7:0] sb [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// encrypt one block, byte 0 on top of both words
	function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
		logic [7:0] rk [16];
		logic [7:0] st [16];
		logic [7:0] t [16];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, s;
		logic [127:0] res;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127-8*i -: 8];
			st[i] = pt[127-8*i -: 8] ^ rk[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[r+4*c] = sb[st[r + 4*((c+r) & 3)]];
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					s = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ s ^ gf_dbl(a0 ^ a1);
					t[4*c+1] = a1 ^ s ^ gf_dbl(a1 ^ a2);
					t[4*c+2] = a2 ^ s ^ gf_dbl(a2 ^ a3);
					t[4*c+3] = a3 ^ s ^ gf_dbl(a3 ^ a0);
				end
			end
			rk[0] = rk[0] ^ sb[rk[13]] ^ rc;
			rk[1] = rk[1] ^ sb[rk[14]];
			rk[2] = rk[2] ^ sb[rk[15]];
			rk[3] = rk[3] ^ sb[rk[12]];
			for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
			rc = gf_dbl(rc);
			for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
		return res;
	endfunction

	// fold the buffered block into the chaining value
	function automatic void compress_block();
		logic [127:0] blk;
		for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = blk_buf[i];
		chain_h = aes_encrypt(chain_h, blk) ^ blk;
	endfunction

	function automatic void hash_clear();
		chain_h  = '0;
		fill_cnt = 0;
		msg_len  = '0;
	endfunction

	// advance the hash by one accepted word; queue a digest on finish
	function automatic void hash_step(input logic w_op, input logic [7:0] w_byte);
		logic [63:0] bits;
		if (w_op == mmo_pkg::OP_ABSORB) begin
			blk_buf[fill_cnt] = w_byte;
			msg_len = msg_len + 1'b1;
			fill_cnt++;
			if (fill_cnt == 16) begin
				compress_block();
				fill_cnt = 0;
			end
			return;
		end
		blk_buf[fill_cnt] = 8'h80;
		fill_cnt++;
		if (fill_cnt > 8) begin
			while (fill_cnt < 16) blk_buf[fill_cnt++] = 8'h00;
			compress_block();
			fill_cnt = 0;
		end
		while (fill_cnt < 8) blk_buf[fill_cnt++] = 8'h00;
		bits = {msg_len, 3'b000};
		for (int i = 0; i < 8; i++) blk_buf[8+i] = bits[63-8*i -: 8];
		compress_block();
		digest_q.push_back(chain_h);
		hash_clear();
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("mmo_aes128_stream_hash_top verification failed");
			$finish;
		end
	end

	// drive one word with a random lead-in gap, hold it until taken
	task automatic send_word(input logic w_op, input logic [7:0] w_byte, input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= w_op;
		data_byte <= w_byte;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hash_step(w_op, w_byte);
		@(negedge clk);
	endtask

	task automatic send_idle();
		in_valid <= 1'b0;
	endtask

	task automatic send_message(input int n, input bit burst = 0);
		for (int i = 0; i < n; i++) send_word(mmo_pkg::OP_ABSORB, 8'($urandom), burst);
		send_word(mmo_pkg::OP_FINISH, 8'($urandom), burst);
	endtask

	task automatic wait_drained();
		send_idle();
		while (digest_q.size() != 0) @(negedge clk);
	endtask

	// check each digest against the oldest prediction
	always @(posedge clk) begin
		logic [127:0] exp_d;
		if (arst_n && out_valid && !out_stall) begin
			rx_wait = $urandom_range(0, 8);
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest %h_%h", digest_hi, digest_lo);
			end else begin
				exp_d = digest_q.pop_front();
				if (exp_d[127:64] !== digest_hi || exp_d[63:0] !== digest_lo) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h_%h got %h_%h",
							exp_d[127:64], exp_d[63:0], digest_hi, digest_lo);
				end
			end
		end
	end

	// receiver waits a drawn number of cycles per word, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_off) begin
			out_stall <= 1'b1;
			if (hold_cycles > 0) hold_cycles--;
			else hold_off = 1'b0;
		end else if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_directed();
		// empty message, then boundary lengths around the padding split
		send_message(0);
		send_message(1);
		send_word(mmo_pkg::OP_ABSORB, 8'h00);
		send_word(mmo_pkg::OP_ABSORB, 8'hff);
		send_word(mmo_pkg::OP_ABSORB, 8'h55);
		send_word(mmo_pkg::OP_ABSORB, 8'haa);
		send_word(mmo_pkg::OP_FINISH, 8'hff);
		send_message(7);
		send_message(8);
		wait_drained();
	endtask

	task automatic test_block_edges();
		int lens [6] = '{15, 16, 17, 23, 24, 32};
		foreach (lens[i]) send_message(lens[i]);
		wait_drained();
	endtask

	task automatic test_random();
		int total;
		int n;
		total = 0;
		while (total < 1100) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 20);
			if ($urandom_range(0, 5) == 0) send_message(n, 1);
			else send_message(n);
			total += n + 1;
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		hold_off    = 1'b1;
		for (int k = 0; k < 12; k++) send_message($urandom_range(0, 40), 1);
		wait_drained();
		send_message(33, 1);
		wait_drained();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = mmo_pkg::OP_ABSORB;
		data_byte   = 8'h00;
		out_stall   = 1'b0;
		hold_off    = 1'b0;
		hold_cycles = 0;
		rx_wait     = 0;
		mismatches  = 0;
		cycle_cnt   = 0;
		hash_clear();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_block_edges();
		test_backpressure();
		test_random();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("mmo_aes128_stream_hash_top verification clean");
		else
			$display("mmo_aes128_stream_hash_top verification failed");
		$finish;
	end

endmodule
